// ----- rtl/lpcm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpcm_pkg: shared types and constants of the layered pixel collision map
// Holds the layer count limit, byte width, configuration and queue entry types.
// ----------------------------------------------------------------------------
package lpcm_pkg;

	localparam int LAYER_SLOTS = 15;
	localparam int ID_W        = 8;
	localparam int KEY_W       = 16;
	localparam int LIU_W       = 4;

	typedef enum logic [1:0] {
		OP_NONE  = 2'd0,
		OP_WRITE = 2'd1,
		OP_PROBE = 2'd2
	} op_t;

	typedef struct packed {
		logic [KEY_W-1:0] key_color;
		logic [LIU_W-1:0] layers_in_use;
	} cfg_t;

	// Classified pixel operation as it crosses the queue (address travels apart).
	typedef struct packed {
		op_t                    op;
		logic                   last;
		logic [ID_W-1:0]        data;
		logic [LAYER_SLOTS-1:0] sel;
	} item_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/lpcm_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpcm_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lpcm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024,
	localparam int AW   = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/lpcm_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpcm_fifo: short queue between the front and the back
// Register-based FIFO with first-word fall-through output.
// ----------------------------------------------------------------------------
module lpcm_fifo #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	output logic                  full,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] pop_data,
	output logic                  empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] store_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	assign full     = (count_q == CW'(DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = store_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			store_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("queue pushed while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("queue popped while empty");

endmodule

`default_nettype wire

// ----- rtl/lpcm_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpcm_front: pixel intake and classification
// Registers an accepted pixel, clips it, computes its layer address and the
// set of layers it touches, and pushes the resulting operation into the queue.
// ----------------------------------------------------------------------------
module lpcm_front #(
	parameter int NUM_LAYERS    = 15,
	parameter int SCREEN_WIDTH  = 640,
	parameter int SCREEN_HEIGHT = 480,
	localparam int ADDR_W = $clog2(SCREEN_WIDTH * SCREEN_HEIGHT),
	localparam int X_W    = $clog2(SCREEN_WIDTH),
	localparam int Y_W    = $clog2(SCREEN_HEIGHT)
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire lpcm_pkg::cfg_t                   cfg,
	input  wire logic                             accept,
	input  wire logic [1:0]                       cmd,
	input  wire logic [lpcm_pkg::LAYER_SLOTS-1:0] layer_mask,
	input  wire logic [11:0]                      pix_x,
	input  wire logic [11:0]                      pix_y,
	input  wire logic [lpcm_pkg::KEY_W-1:0]       src_pixel,
	input  wire logic [lpcm_pkg::ID_W-1:0]        stamp_id,
	input  wire logic                             last_pixel,
	output logic                                  ready,
	output logic                                  push,
	output lpcm_pkg::item_ctl_t                   push_ctl,
	output logic      [ADDR_W-1:0]                push_addr,
	input  wire logic                             queue_full
);

	typedef enum logic [1:0] {
		CMD_CLEAR = 2'd0,
		CMD_STAMP = 2'd1,
		CMD_PROBE = 2'd2
	} cmd_t;

	logic                             valid_s1;
	logic [1:0]                       cmd_s1;
	logic [lpcm_pkg::LAYER_SLOTS-1:0] mask_s1;
	logic [11:0]                      x_s1;
	logic [11:0]                      y_s1;
	logic [lpcm_pkg::KEY_W-1:0]       pix_s1;
	logic [lpcm_pkg::ID_W-1:0]        id_s1;
	logic                             last_s1;

	logic                             on_screen;
	logic                             opaque;
	logic [lpcm_pkg::LAYER_SLOTS-1:0] live;
	logic [lpcm_pkg::LAYER_SLOTS-1:0] mask_all;
	lpcm_pkg::item_ctl_t              ctl;
	logic                             consume;

	always_comb begin
		for (int z = 0; z < lpcm_pkg::LAYER_SLOTS; z++) begin
			live[z] = (z < NUM_LAYERS) &&
				(lpcm_pkg::LIU_W'(z) < cfg.layers_in_use);
		end
	end

	// One extra bit keeps the bound intact for a screen dimension of 2048.
	assign on_screen = !x_s1[11] && ({1'b0, x_s1} < 13'(SCREEN_WIDTH)) &&
		!y_s1[11] && ({1'b0, y_s1} < 13'(SCREEN_HEIGHT));
	assign opaque    = (pix_s1 != cfg.key_color);
	// A zero mask selects every layer for clear and probe.
	assign mask_all  = (mask_s1 == '0) ? '1 : mask_s1;

	always_comb begin
		ctl      = '0;
		ctl.op   = lpcm_pkg::OP_NONE;
		ctl.last = last_s1;
		unique case (cmd_t'(cmd_s1))
			CMD_CLEAR: begin
				ctl.sel = on_screen ? (mask_all & live) : '0;
				ctl.op  = (ctl.sel != '0) ? lpcm_pkg::OP_WRITE : lpcm_pkg::OP_NONE;
			end
			CMD_STAMP: begin
				ctl.data = id_s1;
				ctl.sel  = (on_screen && opaque) ? (mask_s1 & live) : '0;
				ctl.op   = (ctl.sel != '0) ? lpcm_pkg::OP_WRITE : lpcm_pkg::OP_NONE;
			end
			CMD_PROBE: begin
				ctl.sel = (on_screen && opaque) ? (mask_all & live) : '0;
				ctl.op  = lpcm_pkg::OP_PROBE;
			end
			default: begin
				ctl.op = lpcm_pkg::OP_NONE;
			end
		endcase
	end

	assign push_addr = ADDR_W'(y_s1[Y_W-1:0]) * ADDR_W'(SCREEN_WIDTH) +
		ADDR_W'(x_s1[X_W-1:0]);
	assign push_ctl  = ctl;
	assign push      = valid_s1 && (ctl.op != lpcm_pkg::OP_NONE) && !queue_full;
	assign consume   = valid_s1 && ((ctl.op == lpcm_pkg::OP_NONE) || !queue_full);
	assign ready     = !valid_s1 || consume;

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1  <= cmd;
			mask_s1 <= layer_mask;
			x_s1    <= pix_x;
			y_s1    <= pix_y;
			pix_s1  <= src_pixel;
			id_s1   <= stamp_id;
			last_s1 <= last_pixel;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (consume) begin
			valid_s1 <= 1'b0;
		end
	end

	a_stamp_needs_layers: assert property (@(posedge clk) disable iff (!arst_n)
		push && (ctl.op == lpcm_pkg::OP_WRITE) |-> (ctl.sel & ~live) == '0)
		else $error("write selects a layer that does not exist");

endmodule

`default_nettype wire

// ----- rtl/lpcm_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpcm_back: layer memories and probe accumulation
// Runs the reset clearing pass, performs queued writes and probe reads on all
// layers at one address per cycle, tracks the first hit per layer and emits
// the collision result at the end of a probe run.
// ----------------------------------------------------------------------------
module lpcm_back #(
	parameter int NUM_LAYERS    = 15,
	parameter int SCREEN_WIDTH  = 640,
	parameter int SCREEN_HEIGHT = 480,
	localparam int LAYER_DEPTH = SCREEN_WIDTH * SCREEN_HEIGHT,
	localparam int ADDR_W      = $clog2(LAYER_DEPTH)
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          queue_empty,
	input  wire lpcm_pkg::item_ctl_t           item_ctl,
	input  wire logic [ADDR_W-1:0]             item_addr,
	output logic                               pop,
	output logic                               clearing,
	output logic                               done,
	output logic      [lpcm_pkg::ID_W-1:0]     hit_id
);

	logic                             clearing_q;
	logic [ADDR_W-1:0]                clr_addr_q;
	logic [NUM_LAYERS-1:0]            wr_en;
	logic [ADDR_W-1:0]                wr_addr;
	logic [lpcm_pkg::ID_W-1:0]        wr_data;
	logic                             rd_en;
	logic [lpcm_pkg::ID_W-1:0]        rd_data [NUM_LAYERS];

	logic                             probe_s2;
	logic                             last_s2;
	logic [lpcm_pkg::LAYER_SLOTS-1:0] sel_s2;
	logic [lpcm_pkg::ID_W-1:0]        first_hit_q [NUM_LAYERS];
	logic [lpcm_pkg::ID_W-1:0]        new_hit [NUM_LAYERS];
	logic [lpcm_pkg::ID_W-1:0]        hit;
	logic                             any_recorded;
	logic                             done_q;
	logic [lpcm_pkg::ID_W-1:0]        hit_id_q;

	// The queue stays empty while the clearing pass runs, so the back drains
	// one operation every cycle and never holds the queue off.
	assign pop      = !queue_empty;
	assign clearing = clearing_q;
	assign rd_en    = pop && (item_ctl.op == lpcm_pkg::OP_PROBE);
	assign wr_addr  = clearing_q ? clr_addr_q : item_addr;
	assign wr_data  = clearing_q ? '0 : item_ctl.data;

	always_comb begin
		for (int z = 0; z < NUM_LAYERS; z++) begin
			wr_en[z] = clearing_q ||
				(pop && (item_ctl.op == lpcm_pkg::OP_WRITE) && item_ctl.sel[z]);
		end
	end

	for (genvar z = 0; z < NUM_LAYERS; z++) begin : g_layer
		lpcm_ram #(
			.WIDTH (lpcm_pkg::ID_W),
			.DEPTH (LAYER_DEPTH)
		) u_ram (
			.clk     (clk),
			.wr_en   (wr_en[z]),
			.wr_addr (wr_addr),
			.wr_data (wr_data),
			.rd_en   (rd_en),
			.rd_addr (item_addr),
			.rd_data (rd_data[z])
		);
	end

	// A layer keeps its first recorded byte; otherwise it takes a fresh hit.
	always_comb begin
		hit          = '0;
		any_recorded = 1'b0;
		for (int z = 0; z < NUM_LAYERS; z++) begin
			new_hit[z] = (first_hit_q[z] != '0) ? first_hit_q[z] :
				((sel_s2[z] && (rd_data[z] != '0)) ? rd_data[z] : '0);
			any_recorded = any_recorded || (first_hit_q[z] != '0);
		end
		for (int z = NUM_LAYERS - 1; z >= 0; z--) begin
			if (new_hit[z] != '0) begin
				hit = new_hit[z];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
			probe_s2   <= 1'b0;
			last_s2    <= 1'b0;
			sel_s2     <= '0;
			done_q     <= 1'b0;
			for (int z = 0; z < NUM_LAYERS; z++) begin
				first_hit_q[z] <= '0;
			end
		end else begin
			if (clearing_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_addr_q == ADDR_W'(LAYER_DEPTH - 1)) begin
					clearing_q <= 1'b0;
				end
			end
			probe_s2 <= rd_en;
			last_s2  <= item_ctl.last;
			sel_s2   <= item_ctl.sel;
			done_q   <= probe_s2 && last_s2;
			if (probe_s2) begin
				for (int z = 0; z < NUM_LAYERS; z++) begin
					first_hit_q[z] <= last_s2 ? '0 : new_hit[z];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (probe_s2 && last_s2) begin
			hit_id_q <= hit;
		end
	end

	assign done   = done_q;
	assign hit_id = hit_id_q;

	a_done_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(probe_s2 && last_s2))
		else $error("result strobe without a closing probe");

	a_run_forgotten: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !any_recorded)
		else $error("recorded hits survived the end of a probe run");

	a_one_port_use: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> (wr_en == '0))
		else $error("layer read and write in the same cycle");

	a_idle_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> !pop)
		else $error("operation drained during the clearing pass");

endmodule

`default_nettype wire

// ----- rtl/layered_pixel_collision_map_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// layered_pixel_collision_map_top: byte-per-pixel collision layers
// Clears, stamps and probes one pixel per command over up to 15 screen-sized
// layers and reports the first hit of the lowest hit layer per probe run.
//
// Channel   Handshake                 Payload
// command   start in, busy out        cmd, layer_mask, pix_x, pix_y,
//                                     src_pixel, stamp_id, last_pixel
// result    done out (one cycle)      hit_id
// config    cfg_valid in, cfg_ready   cfg_index, cfg_data
//
// One command is taken per cycle while busy is low; all layers are accessed
// at one address in the same cycle, which sets that rate.
// A result follows the probe that closes a run through the front register,
// the queue, the layer read and the done register, on done for one cycle.
// After reset a clearing pass zeroes every layer, one address per cycle, at
// SCREEN_WIDTH * SCREEN_HEIGHT addresses (307200 by default); busy is high.
// The back drains one queued operation per cycle, so the queue never fills
// and busy stays low once the clearing pass has ended.
// ----------------------------------------------------------------------------
module layered_pixel_collision_map_top #(
	parameter int NUM_LAYERS    = 15,
	parameter int SCREEN_WIDTH  = 640,
	parameter int SCREEN_HEIGHT = 480
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	output logic                                  busy,
	input  wire logic [1:0]                       cmd,
	input  wire logic [lpcm_pkg::LAYER_SLOTS-1:0] layer_mask,
	input  wire logic [11:0]                      pix_x,
	input  wire logic [11:0]                      pix_y,
	input  wire logic [lpcm_pkg::KEY_W-1:0]       src_pixel,
	input  wire logic [lpcm_pkg::ID_W-1:0]        stamp_id,
	input  wire logic                             last_pixel,
	output logic                                  done,
	output logic      [lpcm_pkg::ID_W-1:0]        hit_id,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic                             cfg_index,
	input  wire logic [lpcm_pkg::KEY_W-1:0]       cfg_data
);

	localparam int   ADDR_W       = $clog2(SCREEN_WIDTH * SCREEN_HEIGHT);
	localparam int   CTL_W        = $bits(lpcm_pkg::item_ctl_t);
	localparam int   QUEUE_DEPTH  = 4;
	localparam logic REG_KEY      = 1'b0;
	localparam logic REG_LAYERS   = 1'b1;
	localparam logic [lpcm_pkg::KEY_W-1:0] KEY_RESET    = 16'hF81F;
	localparam logic [lpcm_pkg::LIU_W-1:0] LAYERS_RESET = 4'd15;

	lpcm_pkg::cfg_t      cfg_q;
	logic                accept;
	logic                front_ready;
	logic                push;
	lpcm_pkg::item_ctl_t push_ctl;
	logic [ADDR_W-1:0]   push_addr;
	logic                queue_full;
	logic                queue_empty;
	logic                pop;
	logic [CTL_W+ADDR_W-1:0] queue_out;
	lpcm_pkg::item_ctl_t item_ctl;
	logic [ADDR_W-1:0]   item_addr;
	logic                clearing;

	assign cfg_ready = 1'b1;
	assign busy      = clearing || !front_ready;
	assign accept    = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.key_color     <= KEY_RESET;
			cfg_q.layers_in_use <= LAYERS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_KEY:    cfg_q.key_color     <= cfg_data;
				REG_LAYERS: cfg_q.layers_in_use <= cfg_data[lpcm_pkg::LIU_W-1:0];
				default:    ;
			endcase
		end
	end

	lpcm_front #(
		.NUM_LAYERS    (NUM_LAYERS),
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.accept     (accept),
		.cmd        (cmd),
		.layer_mask (layer_mask),
		.pix_x      (pix_x),
		.pix_y      (pix_y),
		.src_pixel  (src_pixel),
		.stamp_id   (stamp_id),
		.last_pixel (last_pixel),
		.ready      (front_ready),
		.push       (push),
		.push_ctl   (push_ctl),
		.push_addr  (push_addr),
		.queue_full (queue_full)
	);

	lpcm_fifo #(
		.WIDTH (CTL_W + ADDR_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({push_ctl, push_addr}),
		.full      (queue_full),
		.pop       (pop),
		.pop_data  (queue_out),
		.empty     (queue_empty)
	);

	assign item_ctl  = lpcm_pkg::item_ctl_t'(queue_out[CTL_W+ADDR_W-1:ADDR_W]);
	assign item_addr = queue_out[ADDR_W-1:0];

	lpcm_back #(
		.NUM_LAYERS    (NUM_LAYERS),
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.queue_empty (queue_empty),
		.item_ctl    (item_ctl),
		.item_addr   (item_addr),
		.pop         (pop),
		.clearing    (clearing),
		.done        (done),
		.hit_id      (hit_id)
	);

endmodule

`default_nettype wire

// ----- tb/lpcm_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpcm_checker: result predictor and comparator for the collision map
// Watches the command, result and configuration channels, keeps its own copy
// of the collision layers and of the per-layer first hits, and compares every
// hit_id against the oldest predicted value.
// ----------------------------------------------------------------------------
package lpcm_tb_pkg;

	typedef enum logic [1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_STAMP  = 2'd1,
		CMD_PROBE  = 2'd2,
		CMD_UNUSED = 2'd3
	} pix_cmd_t;

	localparam logic REG_KEY_COLOR     = 1'b0;
	localparam logic REG_LAYERS_IN_USE = 1'b1;

endpackage

module lpcm_checker #(
	parameter int NUM_LAYERS    = 15,
	parameter int SCREEN_WIDTH  = 640,
	parameter int SCREEN_HEIGHT = 480
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic                             busy,
	input  logic [1:0]                       cmd,
	input  logic [lpcm_pkg::LAYER_SLOTS-1:0] layer_mask,
	input  logic [11:0]                      pix_x,
	input  logic [11:0]                      pix_y,
	input  logic [lpcm_pkg::KEY_W-1:0]       src_pixel,
	input  logic [lpcm_pkg::ID_W-1:0]        stamp_id,
	input  logic                             last_pixel,
	input  logic                             done,
	input  logic [lpcm_pkg::ID_W-1:0]        hit_id,
	input  logic                             cfg_valid,
	input  logic                             cfg_ready,
	input  logic                             cfg_index,
	input  logic [lpcm_pkg::KEY_W-1:0]       cfg_data,
	output int                               fail_count,
	output int                               results_owed
);
	import lpcm_pkg::*;
	import lpcm_tb_pkg::*;

	localparam int               PLANE        = SCREEN_WIDTH * SCREEN_HEIGHT;
	localparam logic [KEY_W-1:0] KEY_RESET    = 16'hF81F;
	localparam logic [LIU_W-1:0] LAYERS_RESET = 4'd15;

	// Sparse copy of the layers: a missing entry reads as zero.
	logic [ID_W-1:0]  layer_mem [int];
	logic [ID_W-1:0]  run_first_hit [NUM_LAYERS];
	logic [KEY_W-1:0] key_color_r = KEY_RESET;
	logic [LIU_W-1:0] layers_used_r = LAYERS_RESET;
	logic [ID_W-1:0]  hit_fifo [$];
	int               errors = 0;
	int               owed = 0;

	assign fail_count   = errors;
	assign results_owed = owed;

	// Applies one pixel command to the copy; returns 1 when it closes a probe run.
	function automatic bit predict_pixel(input pix_cmd_t c, input logic [LAYER_SLOTS-1:0] mask,
			input int x, input int y, input logic [KEY_W-1:0] pix,
			input logic [ID_W-1:0] id, input logic closing, output logic [ID_W-1:0] hit);
		int              live;
		int              addr;
		int              z;
		bit              on_screen;
		logic [ID_W-1:0] b;
		live = (layers_used_r > NUM_LAYERS) ? NUM_LAYERS : layers_used_r;
		on_screen = x >= 0 && x < SCREEN_WIDTH && y >= 0 && y < SCREEN_HEIGHT;
		addr = on_screen ? y * SCREEN_WIDTH + x : 0;
		hit = '0;
		case (c)
			CMD_CLEAR: begin
				if (on_screen)
					for (z = 0; z < live; z++)
						if (mask == '0 || mask[z])
							layer_mem[z * PLANE + addr] = '0;
			end
			CMD_STAMP: begin
				// An empty mask selects nothing for a stamp.
				if (on_screen && pix != key_color_r)
					for (z = 0; z < live; z++)
						if (mask[z])
							layer_mem[z * PLANE + addr] = id;
			end
			CMD_PROBE: begin
				if (on_screen && pix != key_color_r)
					for (z = 0; z < live; z++)
						if (mask == '0 || mask[z]) begin
							b = layer_mem.exists(z * PLANE + addr) ?
								layer_mem[z * PLANE + addr] : '0;
							if (b != '0 && run_first_hit[z] == '0)
								run_first_hit[z] = b;
						end
				if (closing) begin
					for (z = 0; z < NUM_LAYERS; z++) begin
						if (hit == '0 && run_first_hit[z] != '0)
							hit = run_first_hit[z];
						run_first_hit[z] = '0;
					end
					return 1'b1;
				end
			end
			default: ;
		endcase
		return 1'b0;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		logic [ID_W-1:0] want;
		int              z;
		if (!arst_n) begin
			layer_mem.delete();
			for (z = 0; z < NUM_LAYERS; z++)
				run_first_hit[z] = '0;
			key_color_r = KEY_RESET;
			layers_used_r = LAYERS_RESET;
			hit_fifo.delete();
			owed = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_KEY_COLOR:     key_color_r = cfg_data;
					REG_LAYERS_IN_USE: layers_used_r = cfg_data[LIU_W-1:0];
					default: ;
				endcase
			end
			if (done) begin
				if (hit_fifo.size() == 0) begin
					$error("hit_id: unexpected result, actual %0d", hit_id);
					errors++;
				end else begin
					want = hit_fifo.pop_front();
					owed--;
					if (hit_id !== want) begin
						$error("hit_id mismatch: expected %0d, actual %0d", want, hit_id);
						errors++;
					end
				end
			end
			if (start && !busy) begin
				if (predict_pixel(pix_cmd_t'(cmd), layer_mask, $signed(pix_x), $signed(pix_y),
						src_pixel, stamp_id, last_pixel, want)) begin
					hit_fifo.push_back(want);
					owed++;
				end
			end
		end
	end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: top level testbench of the layered pixel collision map
// Runs a directed opening, then phases of random stamp, probe and clear
// windows with noise items under changing key colors and layer counts.
// ----------------------------------------------------------------------------
module tb;
	import lpcm_tb_pkg::*;

	localparam int SCREEN_W      = 640;
	localparam int SCREEN_H      = 480;
	localparam int RANDOM_ITEMS  = 1750;
	localparam int PHASES        = 8;
	localparam int SETTLE_CYCLES = 8;
	// The clearing pass after reset keeps busy high, which is by far the
	// longest quiet stretch of a correct run.
	localparam int IDLE_LIMIT    = 1_000_000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [1:0]  cmd = '0;
	logic [14:0] layer_mask = '0;
	logic [11:0] pix_x = '0;
	logic [11:0] pix_y = '0;
	logic [15:0] src_pixel = '0;
	logic [7:0]  stamp_id = '0;
	logic        last_pixel = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_index = 1'b0;
	logic [15:0] cfg_data = '0;
	logic        busy;
	logic        done;
	logic [7:0]  hit_id;
	logic        cfg_ready;
	int          fail_count;
	int          results_owed;

	logic [15:0] key_now = 16'hF81F;
	int          burst_left = 0;
	int          sent = 0;
	int          idle_cycles = 0;

	always #6 clk = ~clk;

	layered_pixel_collision_map_top dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.layer_mask(layer_mask), .pix_x(pix_x), .pix_y(pix_y), .src_pixel(src_pixel),
		.stamp_id(stamp_id), .last_pixel(last_pixel), .done(done), .hit_id(hit_id),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	lpcm_checker u_chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.layer_mask(layer_mask), .pix_x(pix_x), .pix_y(pix_y), .src_pixel(src_pixel),
		.stamp_id(stamp_id), .last_pixel(last_pixel), .done(done), .hit_id(hit_id),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .fail_count(fail_count), .results_owed(results_owed)
	);

	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic pause_sender(input int n);
		repeat (n) begin
			@(negedge clk);
			start <= 1'b0;
		end
	endtask

	task automatic send_pix(input pix_cmd_t c, input logic [14:0] mask, input int x,
			input int y, input logic [15:0] pix, input logic [7:0] id, input logic closing);
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150) :
				$urandom_range(1, 20);
			pause_sender(($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) :
				$urandom_range(1, 4));
		end
		burst_left--;
		@(negedge clk);
		start <= 1'b1;
		cmd <= c;
		layer_mask <= mask;
		pix_x <= x[11:0];
		pix_y <= y[11:0];
		src_pixel <= pix;
		stamp_id <= id;
		last_pixel <= closing;
		do @(posedge clk); while (busy);
		sent++;
	endtask

	// Leaves cfg_valid high after the transfer; set_config lowers it.
	task automatic write_reg(input logic idx, input logic [15:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic set_config(input logic [15:0] key, input logic [3:0] layers);
		logic [15:0] word;
		word = 16'($urandom_range(0, 65535));
		word[3:0] = layers;
		write_reg(REG_KEY_COLOR, key);
		write_reg(REG_LAYERS_IN_USE, word);
		@(negedge clk);
		cfg_valid <= 1'b0;
		key_now = key;
	endtask

	// Stops the sender until every predicted hit has come back, then lets
	// trailing stamps and clears retire.
	task automatic drain();
		pause_sender(1);
		while (results_owed != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [14:0] pick_mask();
		case ($urandom_range(0, 5))
			0:       return 15'h0000;
			1:       return 15'h7FFF;
			2:       return 15'h0001 << $urandom_range(0, 14);
			default: return 15'($urandom_range(0, 32767));
		endcase
	endfunction

	// Walks a window in raster order; a probe window closes its run on the
	// final pixel, other commands carry a random last flag.
	task automatic sweep(input pix_cmd_t c, input logic [14:0] mask, input int x0, input int y0,
			input int w, input int h, input logic [7:0] id);
		logic [15:0] pix;
		logic        closing;
		int          r;
		int          k;
		for (r = 0; r < h; r++)
			for (k = 0; k < w; k++) begin
				pix = ($urandom_range(0, 4) == 0) ? key_now : 16'($urandom_range(0, 65535));
				closing = (c == CMD_PROBE) ? (r == h - 1 && k == w - 1) :
					1'($urandom_range(0, 1));
				send_pix(c, mask, x0 + k, y0 + r, pix,
					(c == CMD_STAMP) ? id : 8'($urandom_range(0, 255)), closing);
			end
	endtask

	task automatic play_scene();
		int x0;
		int y0;
		int w;
		int h;
		int kind;
		case ($urandom_range(0, 9))
			0: begin
				x0 = SCREEN_W - $urandom_range(1, 6);
				y0 = SCREEN_H - $urandom_range(1, 4);
			end
			1: begin
				x0 = -$urandom_range(0, 3);
				y0 = -$urandom_range(0, 2);
			end
			default: begin
				x0 = $urandom_range(0, 12);
				y0 = $urandom_range(0, 8);
			end
		endcase
		w = $urandom_range(1, 6);
		h = $urandom_range(1, 4);
		kind = $urandom_range(0, 9);
		if (kind <= 3) begin
			sweep(CMD_STAMP, pick_mask(), x0, y0, w, h, 8'($urandom_range(0, 255)));
			if ($urandom_range(0, 1))
				sweep(CMD_PROBE, pick_mask(), x0 + $urandom_range(0, 2) - 1,
					y0 + $urandom_range(0, 2) - 1, w, h, 8'h00);
		end else if (kind <= 6) begin
			sweep(CMD_PROBE, pick_mask(), x0, y0, w, h, 8'h00);
		end else if (kind == 7) begin
			sweep(CMD_CLEAR, pick_mask(), x0, y0, w, h, 8'h00);
		end else begin
			repeat ($urandom_range(1, 4))
				send_pix(pix_cmd_t'($urandom_range(0, 3)), 15'($urandom_range(0, 32767)),
					$urandom_range(0, 4095) - 2048, $urandom_range(0, 4095) - 2048,
					16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)));
		end
	endtask

	initial begin : stimulus
		int ph;
		int phase_end;
		logic [15:0] key;
		logic [3:0]  layers;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed opening under the reset configuration.
		send_pix(CMD_STAMP, 15'h0001, 0, 0, 16'h0000, 8'hFF, 1'b0);
		send_pix(CMD_STAMP, 15'h7FFF, SCREEN_W - 1, SCREEN_H - 1, 16'hFFFF, 8'h01, 1'b1);
		send_pix(CMD_STAMP, 15'h7FFF, 1, 0, 16'hF81F, 8'h55, 1'b0);
		send_pix(CMD_STAMP, 15'h0000, 2, 0, 16'h1234, 8'h77, 1'b0);
		send_pix(CMD_STAMP, 15'h7FFF, -1, 0, 16'h0001, 8'h66, 1'b0);
		send_pix(CMD_STAMP, 15'h7FFF, SCREEN_W, 0, 16'h0001, 8'h66, 1'b0);
		send_pix(CMD_STAMP, 15'h7FFF, 0, SCREEN_H, 16'h0001, 8'h66, 1'b0);
		send_pix(CMD_STAMP, 15'h7FFF, -2048, 2047, 16'h0001, 8'h66, 1'b0);
		send_pix(CMD_STAMP, 15'h7FFF, 2047, -2048, 16'h0001, 8'h66, 1'b0);
		send_pix(CMD_PROBE, 15'h0000, 1, 0, 16'h0001, 8'h00, 1'b0);
		send_pix(CMD_PROBE, 15'h0000, 0, 0, 16'hFFFF, 8'h00, 1'b0);
		send_pix(CMD_PROBE, 15'h4000, SCREEN_W - 1, SCREEN_H - 1, 16'h0000, 8'hFF, 1'b1);
		send_pix(CMD_PROBE, 15'h0000, SCREEN_W - 1, SCREEN_H - 1, 16'hF81F, 8'h00, 1'b1);
		send_pix(CMD_PROBE, 15'h0000, SCREEN_W - 1, SCREEN_H - 1, 16'h07E0, 8'h00, 1'b1);
		send_pix(CMD_PROBE, 15'h7FFF, -1, -1, 16'h0000, 8'h00, 1'b1);
		send_pix(CMD_CLEAR, 15'h0000, 0, 0, 16'h0000, 8'h00, 1'b1);
		send_pix(CMD_PROBE, 15'h0001, 0, 0, 16'h0000, 8'h00, 1'b1);
		send_pix(CMD_UNUSED, 15'h7FFF, 0, 0, 16'h0000, 8'hAA, 1'b1);
		send_pix(CMD_CLEAR, 15'h4000, SCREEN_W - 1, SCREEN_H - 1, 16'hFFFF, 8'h00, 1'b0);
		send_pix(CMD_PROBE, 15'h6000, SCREEN_W - 1, SCREEN_H - 1, 16'h0000, 8'h00, 1'b1);
		drain();
		// With no layers in use nothing is stored and probes find nothing.
		set_config(16'hF81F, 4'd0);
		send_pix(CMD_STAMP, 15'h7FFF, 3, 3, 16'h0000, 8'h42, 1'b0);
		send_pix(CMD_PROBE, 15'h0000, 3, 3, 16'h0000, 8'h00, 1'b1);
		drain();

		for (ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: begin key = 16'h0000; layers = 4'd15; end
				1: begin key = 16'hFFFF; layers = 4'd1; end
				2: begin key = 16'($urandom_range(0, 65535)); layers = 4'd0; end
				3: begin key = 16'hF81F; layers = 4'd7; end
				4: begin key = 16'($urandom_range(0, 65535)); layers = 4'd15; end
				5: begin
					key = 16'($urandom_range(0, 65535));
					layers = 4'($urandom_range(1, 15));
				end
				6: begin key = 16'hFFFF; layers = 4'd14; end
				default: begin key = 16'hF81F; layers = 4'd15; end
			endcase
			set_config(key, layers);
			phase_end = sent + RANDOM_ITEMS / PHASES;
			while (sent < phase_end)
				play_scene();
			drain();
		end

		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
